// ===== rtl/ucd_pkg.sv =====
// shared types and constants for the utf-8 code point decoder
// no dependencies

package ucd_pkg;

    localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
    localparam logic [15:0] CP_ELLIPSIS    = 16'h2026;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;
    localparam logic [20:0] SURR_LO        = 21'h00D800;
    localparam logic [20:0] SURR_HI        = 21'h00DFFF;
    localparam logic [20:0] LATIN1_MAX     = 21'h0000FF;

    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // one queue entry: the results caused by one input item
    typedef struct packed {
        logic        two;
        logic [15:0] cp_a;
        logic [15:0] cp_b;
    } ucd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ucd_qstat_t;

endpackage

// ===== rtl/utf8_codepoint_decoder.sv =====
// top level of the utf-8 code point decoder
// depends on ucd_pkg, ucd_front, ucd_queue, ucd_back

// takes one utf-8 byte per item on the s_ stream and gives code points on the
// m_ stream: latin-1, u+2026, or u+fffd for anything malformed or out of range.
// a byte is taken every cycle while the two-entry queue has room; a byte that
// breaks a pending sequence gives a replacement and, if it would give a code
// point as a lead, that result as well, and the output register gives the two
// results one after the other. leads and inner continuation bytes, and a zero
// with nothing pending, give no result. tlast marks the final result caused by
// one input byte. the queue is written at the accepting edge, and m_tvalid
// rises once the output register has been loaded from the queue.
module utf8_codepoint_decoder
    import ucd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_point
    output logic        m_tlast     // last_of_run
);

    logic       accept;
    logic       push;
    logic       pop;
    ucd_entry_t push_entry;
    ucd_entry_t head;
    ucd_qstat_t stat;

    // front stalls only on a full queue
    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;

    ucd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .push    (push),
        .entry   (push_entry)
    );

    ucd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    ucd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // front never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && stat.full))
        else $error("push into full queue");

    // the first of two results is always the replacement character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata == CP_REPLACEMENT))
        else $error("non-final result is not replacement");

    // the second result of a pair follows right after the first is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast && m_tready) |=> (m_tvalid && m_tlast))
        else $error("second result of pair missing");

    // only latin-1, ellipsis or replacement leave the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 16'h00FF || m_tdata == CP_ELLIPSIS ||
                      m_tdata == CP_REPLACEMENT))
        else $error("code point out of range");

endmodule

// ===== rtl/ucd_front.sv =====
// front part: accepts bytes, keeps the sequence state, classifies each byte
// depends on ucd_pkg

module ucd_front
    import ucd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output ucd_entry_t entry
);

    typedef struct packed {
        logic        emit;
        logic [15:0] cp;
        logic [1:0]  due;
        logic [20:0] pv;
    } lead_t;

    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t l;
        l = '0;
        if (b == 8'h00) begin
            l.emit = 1'b0;
        end else if (b < CONT_TAG) begin
            l.emit = 1'b1;
            l.cp   = {8'h00, b};
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            l.due = 2'd1;
            l.pv  = {16'h0000, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            l.due = 2'd2;
            l.pv  = {17'h00000, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            l.due = 2'd3;
            l.pv  = {18'h00000, b[2:0]};
        end else begin
            l.emit = 1'b1;
            l.cp   = CP_REPLACEMENT;
        end
        return l;
    endfunction

    logic [1:0]  bytes_due_reg, bytes_due_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  min_class_reg, min_class_next;

    lead_t       lead;
    logic [20:0] pv_cont;
    logic [20:0] min_val;
    logic [15:0] final_cp;

    assign lead    = decode_lead(in_byte);
    assign pv_cont = {partial_reg[14:0], in_byte[5:0]};

    always_comb begin
        unique case (min_class_reg)
            2'd0: min_val = 21'h000000;
            2'd1: min_val = 21'h000080;
            2'd2: min_val = 21'h000800;
            2'd3: min_val = 21'h010000;
            default: min_val = 21'h000000;
        endcase
    end

    always_comb begin
        if (pv_cont < min_val || pv_cont > CP_MAX ||
            (pv_cont >= SURR_LO && pv_cont <= SURR_HI)) begin
            final_cp = CP_REPLACEMENT;
        end else if (pv_cont <= LATIN1_MAX || pv_cont == {5'd0, CP_ELLIPSIS}) begin
            final_cp = pv_cont[15:0];
        end else begin
            final_cp = CP_REPLACEMENT;
        end
    end

    always_comb begin
        bytes_due_next = bytes_due_reg;
        partial_next   = partial_reg;
        min_class_next = min_class_reg;
        push           = 1'b0;
        entry          = '0;
        if (accept) begin
            if (bytes_due_reg == 2'd0) begin
                push           = lead.emit;
                entry.cp_a     = lead.cp;
                bytes_due_next = lead.due;
                min_class_next = lead.due;
                partial_next   = lead.pv;
            end else if ((in_byte & CONT_MASK) == CONT_TAG) begin
                bytes_due_next = bytes_due_reg - 2'd1;
                if (bytes_due_reg == 2'd1) begin
                    push           = 1'b1;
                    entry.cp_a     = final_cp;
                    partial_next   = '0;
                    min_class_next = 2'd0;
                end else begin
                    partial_next = pv_cont;
                end
            end else begin
                // broken sequence: replacement, then the byte again as a lead
                push           = 1'b1;
                entry.cp_a     = CP_REPLACEMENT;
                entry.two      = lead.emit;
                entry.cp_b     = lead.cp;
                bytes_due_next = lead.due;
                min_class_next = lead.due;
                partial_next   = lead.pv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_due_reg <= 2'd0;
            partial_reg   <= '0;
            min_class_reg <= 2'd0;
        end else begin
            bytes_due_reg <= bytes_due_next;
            partial_reg   <= partial_next;
            min_class_reg <= min_class_next;
        end
    end

endmodule

// ===== rtl/ucd_queue.sv =====
// two-entry queue between the front and back parts
// depends on ucd_pkg

module ucd_queue
    import ucd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  ucd_entry_t push_entry,
    input  logic       pop,
    output ucd_entry_t head,
    output ucd_qstat_t stat
);

    ucd_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/ucd_back.sv =====
// back part: splits queue entries into results and holds the output register
// depends on ucd_pkg

module ucd_back
    import ucd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ucd_entry_t  head,
    input  ucd_qstat_t  stat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [15:0] data_reg, data_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = (!valid_reg || m_tready) && !stat.empty;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        phase_next = phase_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.two && !phase_reg) begin
                data_next  = head.cp_a;
                last_next  = 1'b0;
                phase_next = 1'b1;
            end else if (head.two) begin
                data_next  = head.cp_b;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end else begin
                data_next = head.cp_a;
                last_next = 1'b1;
                pop       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for utf8_codepoint_decoder: directed byte runs, then
// random well-formed and broken utf-8 under several idle and stall mixes
// depends on ucd_pkg and the utf8_codepoint_decoder rtl

module testbench;
    import ucd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected code point as it should leave the m_ side
    typedef struct packed {
        logic [15:0] cp;
        logic        last;
    } cp_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;             // [15:0] code_point
    logic        m_tlast;             // last_of_run

    // decoder state as the predictor sees it
    logic [1:0]  cont_left = '0;
    logic [20:0] cp_accum  = '0;
    logic [1:0]  len_class = '0;

    cp_result_t  pending_cps[$];      // code points still owed by the block

    int          send_idle    = 0;    // percent of cycles the sender idles
    int          recv_stall   = 0;    // percent of cycles with m_tready low
    logic        hold_rx      = 1'b0; // long receiver hold-off in progress
    int          errors       = 0;
    int          items_sent   = 0;
    int          results_seen = 0;

    utf8_codepoint_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // run limit, far above the slowest legal run
    initial begin
        #4_000_000;
        $display("utf8_codepoint_decoder test failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 30) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // byte seen with no sequence pending; returns 1 when it yields a code point
    function automatic bit lead_result(input logic [7:0] b, output logic [15:0] cp);
        cp = CP_REPLACEMENT;
        if (b == 8'h00) begin
            return 1'b0;                       // end of text, nothing pending
        end
        if (b < 8'h80) begin
            cp = {8'h00, b};                   // plain ascii
            return 1'b1;
        end
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            cont_left = 2'd1;
            len_class = 2'd1;
            cp_accum  = {16'h0000, b[4:0]};
            return 1'b0;
        end
        if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            cont_left = 2'd2;
            len_class = 2'd2;
            cp_accum  = {17'h00000, b[3:0]};
            return 1'b0;
        end
        if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            cont_left = 2'd3;
            len_class = 2'd3;
            cp_accum  = {18'h00000, b[2:0]};
            return 1'b0;
        end
        return 1'b1;                           // stray continuation or bad lead
    endfunction

    // advances the predicted state by one byte; returns how many code points it gives
    function automatic int decode_byte(input logic [7:0] b,
                                       output logic [15:0] r0, output logic [15:0] r1);
        int          n;
        logic [15:0] cp;
        logic [20:0] lowest;
        n  = 0;
        r0 = CP_REPLACEMENT;
        r1 = CP_REPLACEMENT;
        if (cont_left == 2'd0) begin
            if (lead_result(b, cp)) begin
                r0 = cp;
                n  = 1;
            end
        end else if ((b & CONT_MASK) == CONT_TAG) begin
            cp_accum  = {cp_accum[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                case (len_class)
                    2'd1:    lowest = 21'h000080;
                    2'd2:    lowest = 21'h000800;
                    2'd3:    lowest = 21'h010000;
                    default: lowest = 21'h000000;
                endcase
                // overlong, beyond the code space or a surrogate
                if (cp_accum < lowest || cp_accum > CP_MAX ||
                    (cp_accum >= SURR_LO && cp_accum <= SURR_HI)) begin
                    r0 = CP_REPLACEMENT;
                end else if (cp_accum <= LATIN1_MAX || cp_accum == CP_ELLIPSIS) begin
                    r0 = cp_accum[15:0];
                end else begin
                    r0 = CP_REPLACEMENT;
                end
                cp_accum  = '0;
                len_class = '0;
                n         = 1;
            end
        end else begin
            // sequence broken: replacement first, then the byte again as a lead
            cont_left = '0;
            cp_accum  = '0;
            len_class = '0;
            r0        = CP_REPLACEMENT;
            n         = 1;
            if (lead_result(b, cp)) begin
                r1 = cp;
                n  = 2;
            end
        end
        return n;
    endfunction

    // offers one item, waits for the handshake and books its code points
    task automatic send_byte(input logic [7:0] b);
        int          n;
        logic [15:0] r0;
        logic [15:0] r1;
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        n = decode_byte(b, r0, r1);
        if (n >= 1) begin
            pending_cps.push_back('{cp: r0, last: (n == 1)});
        end
        if (n == 2) begin
            pending_cps.push_back('{cp: r1, last: 1'b1});
        end
    endtask

    // sender stops until every booked code point has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_cont();
        return {2'b10, 6'($urandom)};
    endfunction

    // one random sequence: mostly well-formed with random payload, some noise
    task automatic send_random_seq();
        int         kind;
        int         len;
        int         k;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 20) begin
            send_byte(8'($urandom_range(8'h01, 8'h7F)));
        end else if (kind < 40) begin
            // c2/c3 land in latin-1, the rest of the range is out of reach
            if ($urandom_range(1)) send_byte(8'($urandom_range(LEAD2_LO, LEAD2_LO + 1)));
            else send_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
            send_byte(rand_cont());
        end else if (kind < 55) begin
            if ($urandom_range(3) == 0) begin
                send_byte(8'hE2); send_byte(8'h80); send_byte(8'hA6);
            end else begin
                send_byte(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
                send_byte(rand_cont());
                send_byte(rand_cont());
            end
        end else if (kind < 65) begin
            send_byte(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
            repeat (3) send_byte(rand_cont());
        end else if (kind < 73) begin
            // bad lead: stray continuation, c0/c1, or f5-ff
            if ($urandom_range(1)) send_byte(8'($urandom_range(8'h80, 8'hC1)));
            else send_byte(8'($urandom_range(8'hF5, 8'hFF)));
        end else if (kind < 85) begin
            // truncated sequence followed by anything that is not a continuation
            len = $urandom_range(1, 3);
            case (len)
                1:       send_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                2:       send_byte(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
                default: send_byte(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
            endcase
            for (k = 0; k < $urandom_range(0, len - 1); k++) begin
                send_byte(rand_cont());
            end
            b = 8'($urandom);
            while ((b & CONT_MASK) == CONT_TAG) b = 8'($urandom);
            send_byte(b);
        end else if (kind < 90) begin
            send_byte(8'h00);
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) send_random_seq();
    endtask

    // checks every result against the oldest booked code point, drives m_tready
    always @(posedge aclk) begin : check_results
        cp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_cps.size() == 0) begin
                flag_error($sformatf("unexpected result cp=%h last=%b", m_tdata, m_tlast));
            end else begin
                want = pending_cps.pop_front();
                if (m_tdata !== want.cp) begin
                    flag_error($sformatf("code_point got %h want %h", m_tdata, want.cp));
                end
                if (m_tlast !== want.last) begin
                    flag_error($sformatf("last_of_run got %b want %b (cp %h)",
                                         m_tlast, want.last, want.cp));
                end
            end
        end
        m_tready <= !hold_rx && ($urandom_range(99) >= recv_stall);
    end

    // ascii limits and end of text with nothing pending
    task automatic test_ascii();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h01);
    endtask

    // two-byte forms at both ends of the upper half of latin-1
    task automatic test_two_byte();
        send_byte(8'hC2); send_byte(8'h80);
        send_byte(8'hC3); send_byte(8'hBF);
    endtask

    // ellipsis, and a surrogate that must be replaced
    task automatic test_three_byte();
        send_byte(8'hE2); send_byte(8'h80); send_byte(8'hA6);
        send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
    endtask

    // four-byte form beyond the top of the code space
    task automatic test_four_byte();
        send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    endtask

    // invalid leads while idle
    task automatic test_bad_lead();
        send_byte(8'h80);
        send_byte(8'hFF);
    endtask

    // broken sequences: by ascii, by end of text, and by a new lead
    task automatic test_broken();
        send_byte(8'hC3); send_byte(8'h41);
        send_byte(8'hE2); send_byte(8'h00);
        send_byte(8'hE2); send_byte(8'hC3); send_byte(8'hA9);
    endtask

    // receiver held off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        send_idle  = 0;
        recv_stall = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx <= 1'b0;
            end
        join_none
        run_random(40);
        wait_drained();
    endtask

    // random traffic under the four idle and stall mixes
    task automatic test_random_mix();
        send_idle = 0;  recv_stall = 0;  run_random(96); wait_drained();
        send_idle = 74; recv_stall = 0;  run_random(96); wait_drained();
        send_idle = 0;  recv_stall = 74; run_random(96); wait_drained();
        send_idle = 38; recv_stall = 38; run_random(96); wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ascii();
        test_two_byte();
        test_three_byte();
        test_four_byte();
        test_bad_lead();
        test_broken();
        wait_drained();

        test_backpressure();
        test_random_mix();

        // anything still booked after the tail is a lost result
        repeat (8) @(posedge aclk);
        if (pending_cps.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_cps.size()));
        end

        $display("covered %0d input bytes giving %0d code points, with sender gaps,",
                 items_sent, results_seen);
        $display("receiver stalls and one 300-cycle output hold-off");
        if (errors == 0) begin
            $display("utf8_codepoint_decoder test passed");
        end else begin
            $display("utf8_codepoint_decoder test failed");
        end
        $finish;
    end

endmodule
